### rtl/core/tbmc_pkg.sv
package tbmc_pkg;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_RDCTL = 3'd2;
    localparam logic [2:0] OP_RDTAP = 3'd3;
    localparam logic [2:0] OP_LINE  = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    localparam logic [2:0] CFG_ATTACHED = 3'd0;
    localparam logic [2:0] CFG_WLOCK    = 3'd1;
    localparam logic [2:0] CFG_TMSW     = 3'd2;
    localparam logic [2:0] CFG_DSHORT   = 3'd3;
    localparam logic [2:0] CFG_DMID     = 3'd4;
    localparam logic [2:0] CFG_DLONG    = 3'd5;

    localparam logic [1:0] PH_NULL   = 2'd0;
    localparam logic [1:0] PH_RQ     = 2'd1;
    localparam logic [1:0] PH_ACTIVE = 2'd2;

    localparam logic [8:0] MK_SPACE_MASK  = 9'o477;
    localparam logic [8:0] MK_BM_SPACE_V  = 9'o425;
    localparam logic [8:0] MK_BM_SYNC_V   = 9'o751;
    localparam logic [8:0] MK_DATA_SYNC_V = 9'o632;
    localparam logic [8:0] MK_BM_END_V    = 9'o526;
    localparam logic [8:0] MK_FEND_A      = 9'o773;
    localparam logic [8:0] MK_FEND_B      = 9'o473;
    localparam logic [8:0] MK_REND_A      = 9'o610;
    localparam logic [8:0] MK_REND_B      = 9'o410;
    localparam logic [8:0] MK_END_V       = 9'o622;
    localparam logic [8:0] MK_DATA_V      = 9'o470;
    localparam logic [7:0] TD_GATE        = 8'o102;

    // command bits
    localparam int CB_USEL = 5;
    localparam int CB_TEEN = 4;
    localparam int CB_JDEN = 3;
    localparam int CB_GO   = 2;
    localparam int CB_REV  = 1;
    localparam int CB_TEN  = 0;
    // status flags
    localparam int SF_INCOMP = 6;
    localparam int SF_WREN   = 5;
    localparam int SF_TIME   = 4;
    localparam int SF_INFO   = 3;
    localparam int SF_ILL    = 2;
    localparam int SF_TEND   = 1;
    localparam int SF_JDONE  = 0;

    typedef struct packed {
        logic [5:0]  command_bits;
        logic [1:0]  time_code;
        logic [2:0]  function_code;
        logic [2:0]  unit_number;
        logic [2:0]  interrupt_level;
        logic [6:0]  status_flags;
        logic [1:0]  rw_phase;
        logic        start_delay_active;
        logic [19:0] delay_count;
        logic        unit_selected;
        logic [8:0]  mark_shift;
        logic [3:0]  block_window;
        logic [7:0]  data_window;
        logic [5:0]  mark_check_ring;
        logic        mark_check_on;
        logic [5:0]  line_parity;
        logic [5:0]  char_buffer;
        logic [2:0]  write_bits;
        logic        half_toggle;
        logic [3:0]  current_line;
        logic [2:0]  sel_unit;
    } ctl_state_t;

    typedef struct packed {
        logic [7:0]  attached_units;
        logic [7:0]  write_locked_units;
        logic        timing_mark_switch;
        logic [19:0] delay_short_ticks;
        logic [19:0] delay_mid_ticks;
        logic [19:0] delay_long_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [35:0] bus_word;
        logic [3:0]  tape_line;
        logic [5:0]  channel_data;
        logic        channel_disconnect;
    } item_t;

    typedef struct packed {
        logic [16:0] read_data;
        logic        tape_write_enable;
        logic [3:0]  tape_write_value;
        logic        channel_exchange;
        logic [5:0]  channel_out;
        logic        channel_reverse;
        logic        motion_go;
        logic        motion_reverse;
        logic [6:0]  interrupt_request;
    } result_t;

endpackage

### rtl/core/tbmc_step.sv
// Next-state and result logic for one transaction.
module tbmc_step #(
    parameter int UNIT_COUNT = 8
) (
    input  tbmc_pkg::ctl_state_t st,
    input  tbmc_pkg::cfg_t       cfg,
    input  tbmc_pkg::item_t      item,
    output tbmc_pkg::ctl_state_t st_next,
    output tbmc_pkg::result_t    res
);
    import tbmc_pkg::*;

    function automatic ctl_state_t sel_unit_f(ctl_state_t s, cfg_t c);
        logic ok;
        ok = (s.command_bits[CB_USEL] || s.unit_number >= 3'd2)
             && ({1'b0, s.unit_number} < 4'(UNIT_COUNT))
             && c.attached_units[s.unit_number];
        s.unit_selected = ok;
        if (ok) s.sel_unit = s.unit_number;
        return s;
    endfunction

    always_comb begin
        ctl_state_t s;
        logic is_wr, is_bm, is_all, is_dat, rev, locked, wasdone, mk, dend, space, sync;
        logic [3:0] mask, tbmedge;
        logic [7:0] tdedge;
        logic [8:0] m;
        logic [2:0] d;
        logic xf, xr, fire;
        logic [5:0] xo;
        logic [3:0] wval;
        logic wen;
        logic [16:0] rd;
        logic any;
        s = st;
        xf = 1'b0; xr = 1'b0; xo = '0; wen = 1'b0; wval = '0; rd = '0; fire = 1'b0;
        is_wr = 1'b0; is_bm = 1'b0; is_all = 1'b0; is_dat = 1'b0; rev = 1'b0;
        locked = 1'b0; wasdone = 1'b0; mk = 1'b0; dend = 1'b0; space = 1'b0;
        mask = '0; tbmedge = '0; tdedge = '0; m = '0; d = '0; sync = 1'b0; any = 1'b0;
        unique case (item.opcode)
            OP_CLEAR: begin
                s.status_flags = '0; s.command_bits = '0; s.time_code = '0;
                s.function_code = '0; s.unit_number = '0; s.interrupt_level = '0;
                s.rw_phase = PH_NULL;
            end
            OP_SET: begin
                s.command_bits    = s.command_bits | item.bus_word[34:29];
                s.time_code       = s.time_code | item.bus_word[28:27];
                s.function_code   = s.function_code | item.bus_word[26:24];
                s.unit_number     = s.unit_number | item.bus_word[23:21];
                s.interrupt_level = s.interrupt_level | item.bus_word[20:18];
                s = sel_unit_f(s, cfg);
                if (s.time_code == 2'd0) begin
                    s.rw_phase = PH_RQ;
                end else begin
                    s.delay_count = (s.time_code == 2'd1) ? cfg.delay_short_ticks :
                                    (s.time_code == 2'd2) ? cfg.delay_mid_ticks :
                                                            cfg.delay_long_ticks;
                    s.start_delay_active = 1'b1;
                    s.block_window = '0; s.data_window = '0; s.mark_shift = '0;
                    s.mark_check_on = 1'b0;
                end
            end
            OP_RDCTL: begin
                rd = {s.command_bits, s.time_code, s.function_code, s.unit_number,
                      s.interrupt_level};
            end
            OP_RDTAP: begin
                rd = {6'd0, s.start_delay_active, s.rw_phase == PH_RQ,
                      s.rw_phase == PH_ACTIVE, s.rw_phase == PH_NULL, s.status_flags};
            end
            OP_LINE: begin
                if (s.status_flags[SF_TEND]) s.command_bits[CB_GO] = 1'b0;
                if (s.unit_selected && s.command_bits[CB_GO]) begin
                    is_wr  = s.function_code[2];
                    is_bm  = s.function_code[1:0] == 2'd2;
                    is_all = s.function_code[1:0] == 2'd1;
                    is_dat = s.function_code[1:0] == 2'd3;
                    rev    = s.command_bits[CB_REV];
                    locked = cfg.write_locked_units[s.sel_unit];
                    mask   = rev ? 4'hF : 4'h0;
                    wasdone = s.status_flags[SF_JDONE];
                    s.current_line = item.tape_line ^ mask;
                    if (s.rw_phase == PH_ACTIVE) begin
                        s.status_flags[SF_WREN] = 1'b1;
                        if (is_wr) begin
                            s.write_bits = s.half_toggle ? s.char_buffer[2:0]
                                                         : s.char_buffer[5:3];
                            if (rev) s.write_bits = s.write_bits ^ 3'd7;
                            if (locked) s.status_flags[SF_ILL] = 1'b1;
                        end
                    end
                    if (is_wr && s.status_flags[SF_WREN] && !locked) begin
                        wen = 1'b1;
                        if (s.function_code == 3'd4 && cfg.timing_mark_switch)
                            wval = {s.write_bits[2], s.write_bits} ^ mask;
                        else
                            wval = {s.current_line[3], s.write_bits} ^ mask;
                    end
                    if (is_wr) s.write_bits = s.write_bits ^ 3'd7;
                    if (!s.start_delay_active && s.function_code != 3'd4)
                        s.mark_shift = {s.mark_shift[8] | s.mark_shift[7],
                                        s.mark_shift[6:0], s.current_line[3]};
                    if (s.rw_phase == PH_ACTIVE && !is_wr) begin
                        d = s.current_line[2:0] ^
                            ((rev && s.function_code != 3'd2) ? 3'd7 : 3'd0);
                        s.char_buffer = s.char_buffer |
                                        (s.half_toggle ? {3'd0, d} : {d, 3'd0});
                    end
                    m = s.mark_shift;
                    if (s.rw_phase == PH_ACTIVE) begin
                        if (s.half_toggle) begin
                            s.line_parity = s.line_parity ^ ~s.char_buffer;
                            if (!is_wr && (s.data_window & TD_GATE) == 8'd0) begin
                                xf = 1'b1; xo = s.char_buffer;
                                xr = rev && s.function_code != 3'd2;
                                s.char_buffer = s.char_buffer | item.channel_data;
                                if (item.channel_disconnect)
                                    s.status_flags[SF_INCOMP] = 1'b1;
                            end
                        end
                        s.half_toggle = ~s.half_toggle;
                        if (is_bm && m == MK_BM_END_V) s.status_flags[SF_JDONE] = 1'b1;
                        if (!is_all && (m == MK_BM_SYNC_V || m == MK_DATA_SYNC_V)) begin
                            s.status_flags[SF_INFO] = 1'b1;
                            s.rw_phase = PH_NULL;
                        end
                    end else begin
                        s.half_toggle = 1'b0;
                    end
                    dend  = m == MK_FEND_A || m == MK_FEND_B || m == MK_REND_A ||
                            m == MK_REND_B;
                    space = (m & MK_SPACE_MASK) == MK_BM_SPACE_V;
                    sync  = m == MK_BM_SYNC_V;
                    mk = m == MK_BM_END_V || sync || dend || m == MK_DATA_SYNC_V ||
                         m == MK_DATA_V;
                    if (s.mark_check_on && (mk != (s.mark_check_ring == 6'o40)))
                        s.status_flags[SF_INFO] = 1'b1;
                    if (!space)
                        s.mark_check_ring = {s.mark_check_ring[0], s.mark_check_ring[5:1]};
                    tbmedge = ~s.block_window;
                    if (sync) s.block_window = {1'b1, s.block_window[3:1]};
                    else if (space) s.block_window = {1'b0, s.block_window[3:1]};
                    tbmedge = tbmedge & s.block_window;
                    tdedge = s.data_window;
                    if (m == MK_DATA_SYNC_V) s.data_window = {1'b1, s.data_window[7:1]};
                    else if (dend) s.data_window = {1'b0, s.data_window[7:1]};
                    tdedge = tdedge ^ s.data_window;
                    if (tdedge[6] && s.data_window[6]) s.line_parity = '0;
                    if (s.rw_phase == PH_RQ) begin
                        if ((is_bm && tbmedge[0]) || (is_all && tbmedge[3]) ||
                            (is_dat && tdedge[6] && s.data_window[6]))
                            s.rw_phase = PH_ACTIVE;
                    end else if (s.rw_phase == PH_ACTIVE && is_dat && tdedge[1] &&
                                 !s.data_window[1]) begin
                        if (item.channel_disconnect) s.status_flags[SF_JDONE] = 1'b1;
                        else s.rw_phase = PH_RQ;
                    end
                    if (s.status_flags[SF_JDONE] && !wasdone) s.rw_phase = PH_NULL;
                    if (s.rw_phase == PH_ACTIVE && !s.half_toggle) s.char_buffer = '0;
                    if (!is_wr && (is_all || is_dat) && s.data_window[0] &&
                        s.line_parity != 6'o77)
                        s.status_flags[SF_INFO] = 1'b1;
                    if (s.block_window[0]) begin
                        if (space) s.mark_check_ring = 6'o40;
                        else s.mark_check_on = 1'b1;
                    end
                    if (sync) s.mark_check_on = 1'b0;
                    if (m == MK_END_V) begin
                        s.status_flags[SF_TEND] = 1'b1;
                        s.rw_phase = PH_NULL;
                    end
                    if (s.rw_phase != PH_ACTIVE) begin
                        s.status_flags[SF_WREN] = 1'b0;
                    end else if (!s.half_toggle) begin
                        if (is_wr && is_dat && s.data_window[1])
                            s.char_buffer = s.char_buffer | s.line_parity;
                        if ((is_wr && (s.data_window & TD_GATE) == 8'd0) ||
                            s.function_code == 3'd4) begin
                            xf = 1'b1; xo = s.char_buffer; xr = rev;
                            s.char_buffer = s.char_buffer | item.channel_data;
                            if (item.channel_disconnect)
                                s.status_flags[SF_INCOMP] = 1'b1;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (s.start_delay_active) begin
                    if (s.delay_count == 20'd0) fire = 1'b1;
                    else s.delay_count = s.delay_count - 20'd1;
                    if (fire) begin
                        s.start_delay_active = 1'b0;
                        s.status_flags[SF_TIME] = 1'b1;
                        s = sel_unit_f(s, cfg);
                        if (!s.unit_selected) begin
                            s.command_bits[CB_GO] = 1'b0;
                            s.status_flags[SF_ILL] = 1'b1;
                        end
                        if ((s.function_code == 3'd4) != cfg.timing_mark_switch)
                            s.status_flags[SF_ILL] = 1'b1;
                        if (s.function_code == 3'd4) s.rw_phase = PH_ACTIVE;
                        else if (s.function_code != 3'd0) s.rw_phase = PH_RQ;
                    end
                end
                if (s.status_flags[SF_TEND]) s.command_bits[CB_GO] = 1'b0;
            end
            default: ;
        endcase
        any = (s.status_flags[SF_TIME] && s.command_bits[CB_TEN]) ||
              (s.status_flags[SF_JDONE] && s.command_bits[CB_JDEN]) ||
              (s.status_flags[SF_TEND] && s.command_bits[CB_TEEN]) ||
              s.status_flags[SF_ILL] || s.status_flags[SF_INFO];
        res.read_data         = rd;
        res.tape_write_enable = wen;
        res.tape_write_value  = wval;
        res.channel_exchange  = xf;
        res.channel_out       = xo;
        res.channel_reverse   = xr;
        res.motion_go         = s.unit_selected && s.command_bits[CB_GO];
        res.motion_reverse    = s.unit_selected && s.command_bits[CB_REV];
        res.interrupt_request = (s.interrupt_level != 3'd0 && any) ?
                                7'(8'h80 >> s.interrupt_level) : 7'd0;
        st_next = s;
    end
endmodule

### rtl/core/tbmc_cfg.sv
// Configuration register file.
module tbmc_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    output tbmc_pkg::cfg_t      cfg
);
    import tbmc_pkg::*;

    cfg_t cfg_reg;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{attached_units: 8'd0, write_locked_units: 8'd0,
                         timing_mark_switch: 1'b0, delay_short_ticks: 20'd35000,
                         delay_mid_ticks: 20'd225000, delay_long_ticks: 20'd300000};
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ATTACHED: cfg_reg.attached_units     <= cfg_data[7:0];
                CFG_WLOCK:    cfg_reg.write_locked_units <= cfg_data[7:0];
                CFG_TMSW:     cfg_reg.timing_mark_switch <= cfg_data[0];
                CFG_DSHORT:   cfg_reg.delay_short_ticks  <= cfg_data;
                CFG_DMID:     cfg_reg.delay_mid_ticks    <= cfg_data;
                CFG_DLONG:    cfg_reg.delay_long_ticks   <= cfg_data;
                default: ;
            endcase
        end
    end
endmodule

### rtl/core/tape_block_mark_controller.sv
// Channel  | Dir | Handshake            | Payload
// s_axis   | in  | s_tvalid / s_tready  | s_tdata: opcode, bus_word, tape_line,
//          |     |                      |          channel_data, channel_disconnect
// m_axis   | out | m_tvalid / m_tready  | m_tdata: result fields, see port
// cfg      | in  | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls: the controller state updates
// in the same cycle a transaction is taken, and its result lands in the output register.
// m_tvalid rises in the cycle after an input is accepted.
// aresetn (synchronous) clears state and the output valid flag and restores config defaults.
// A stalled output holds; input is taken when the output register is free or
// being drained that cycle.
module tape_block_mark_controller #(
    parameter int UNIT_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [38:3] bus_word, [42:39] tape_line, [48:43] channel_data,
    // [49] channel_disconnect, [55:50] zero
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [16:0] read_data, [17] tape_write_enable, [21:18] tape_write_value,
    // [22] channel_exchange, [28:23] channel_out, [29] channel_reverse,
    // [30] motion_go, [31] motion_reverse, [38:32] interrupt_request, [39] zero
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import tbmc_pkg::*;

    cfg_t       cfg;
    ctl_state_t state_reg, state_next;
    item_t      item;
    result_t    res, res_reg;
    logic       valid_reg;
    logic       take;

    tbmc_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    assign item = '{opcode: s_tdata[2:0], bus_word: s_tdata[38:3],
                    tape_line: s_tdata[42:39], channel_data: s_tdata[48:43],
                    channel_disconnect: s_tdata[49]};

    tbmc_step #(.UNIT_COUNT(UNIT_COUNT)) u_step (
        .st(state_reg), .cfg(cfg), .item(item), .st_next(state_next), .res(res)
    );

    assign s_tready = !valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, res_reg.interrupt_request, res_reg.motion_reverse,
                       res_reg.motion_go, res_reg.channel_reverse, res_reg.channel_out,
                       res_reg.channel_exchange, res_reg.tape_write_value,
                       res_reg.tape_write_enable, res_reg.read_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (take) state_reg <= state_next;
            if (take) valid_reg <= 1'b1;
            else if (m_tready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) res_reg <= res;
    end
endmodule
